>>> sv/fnvsrd_pkg.sv
// ----------------------------------------------------------------------------
// fnvsrd_pkg
// Shared types and constants for the FNV-1a 64-bit sample record digest.
// ----------------------------------------------------------------------------
package fnvsrd_pkg;

  typedef logic [63:0] word64_t;
  typedef logic [31:0] word32_t;
  typedef logic [7:0]  byte_t;

  // Offset basis used here, 1469598103934665603 (not the standard FNV-1a 64-bit value)
  localparam word64_t FNV_OFFSET = 64'h1465_0fb0_739d_0383;

  // FNV 64-bit prime is 2^40 + 0x1b3
  localparam int unsigned   FNV_PRIME_HI_SHIFT = 40;
  localparam logic [8:0]    FNV_PRIME_LO       = 9'h1b3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SCHEMA_VERSION = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_SAMPLE_COUNT   = cfg_idx_t'(1);

endpackage

>>> sv/fnvsrd_if.sv
// ----------------------------------------------------------------------------
// fnvsrd_if
// Valid/ready channels: sample words in, digest words out, register writes.
// ----------------------------------------------------------------------------
interface fnvsrd_sample_if
  import fnvsrd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  word64_t sequence_number;
  word64_t timestamp_ns;
  word32_t x_bits;
  word32_t y_bits;
  word32_t pressure_bits;
  logic    predicted;
  logic    carries_sample;
  logic    last_of_trace;

  modport source (
    output valid, sequence_number, timestamp_ns, x_bits, y_bits, pressure_bits,
           predicted, carries_sample, last_of_trace,
    input  ready
  );
  modport sink (
    input  valid, sequence_number, timestamp_ns, x_bits, y_bits, pressure_bits,
           predicted, carries_sample, last_of_trace,
    output ready
  );
endinterface

interface fnvsrd_digest_if
  import fnvsrd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  word64_t digest;

  modport source (output valid, digest, input ready);
  modport sink   (input valid, digest, output ready);
endinterface

interface fnvsrd_cfg_if
  import fnvsrd_pkg::*;
  ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word32_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/fnvsrd_round.sv
// ----------------------------------------------------------------------------
// fnvsrd_round
// One FNV-1a round: xor a byte into the digest, multiply by the FNV prime.
// ----------------------------------------------------------------------------
module fnvsrd_round
  import fnvsrd_pkg::*;
(
  input  word64_t digest_i,
  input  byte_t   byte_i,
  output word64_t digest_o
);

  word64_t mixed;
  word64_t lo_prod;

  assign mixed = digest_i ^ {56'd0, byte_i};

  // low part of the prime as shift-add, the 2^40 term as one more shift
  always_comb begin
    lo_prod = '0;
    for (int i = 0; i < 9; i++) begin
      if (FNV_PRIME_LO[i]) begin
        lo_prod = lo_prod + (mixed << i);
      end
    end
  end

  assign digest_o = lo_prod + (mixed << FNV_PRIME_HI_SHIFT);

endmodule

>>> sv/fnv1a64_sample_record_digest.sv
// A word is taken in the idle state; then its bytes are absorbed (48 for a sample,
//   16 more when it opens a trace) and a trace's digest word is registered once the
//   output slot is free. No new word is taken before that. The single shared FNV round
//   unit absorbs one byte per cycle, so the byte sequencer sets the rate.
// Reset (rst_ni low, asynchronous): schema version 1, sample count 0, digest at
//   the offset basis, no trace open, output empty. No clearing pass.
// ----------------------------------------------------------------------------
// fnv1a64_sample_record_digest
// FNV-1a 64-bit digest over a trace of pointer samples, one byte per cycle.
// ----------------------------------------------------------------------------
module fnv1a64_sample_record_digest
  import fnvsrd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  fnvsrd_cfg_if.sink      cfg_i,
  fnvsrd_sample_if.sink   sample_i,
  fnvsrd_digest_if.source digest_o
);

  // IDLE takes a word, RUN absorbs bytes, FIN closes the word out
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // absorption order; every value goes in as eight bytes, LSB first
  typedef enum logic [2:0] {
    F_SCHEMA,
    F_COUNT,
    F_SEQ,
    F_TS,
    F_X,
    F_Y,
    F_PRESS,
    F_PRED
  } field_e;

  localparam logic [2:0] BYTE_LAST = 3'(7);

  // -- configuration registers -----------------------------------------------
  word32_t schema_q;
  word32_t count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      schema_q <= 32'd1;
      count_q  <= 32'd0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_SCHEMA_VERSION: schema_q <= cfg_i.data;
        CFG_SAMPLE_COUNT:   count_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // -- captured sample word (payload, no reset) ------------------------------
  word64_t seq_q;
  word64_t ts_q;
  word32_t x_q;
  word32_t y_q;
  word32_t press_q;
  logic    pred_q;
  logic    carries_q;
  logic    last_q;

  // -- sequencer state -------------------------------------------------------
  state_e     state_q, state_d;
  field_e     field_q, field_d;
  logic [2:0] byte_q,  byte_d;
  word64_t    h_q,     h_d;
  logic       open_q,  open_d;
  logic       out_valid_q, out_valid_d;
  word64_t    out_digest_q, out_digest_d;

  logic in_fire;
  logic out_fire;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_fire       = digest_o.valid && digest_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seq_q     <= sample_i.sequence_number;
      ts_q      <= sample_i.timestamp_ns;
      x_q       <= sample_i.x_bits;
      y_q       <= sample_i.y_bits;
      press_q   <= sample_i.pressure_bits;
      pred_q    <= sample_i.predicted;
      carries_q <= sample_i.carries_sample;
      last_q    <= sample_i.last_of_trace;
    end
  end

  // byte select: field value widened to 64 bits, then one byte of it
  word64_t value;
  byte_t   cur_byte;
  word64_t h_round;
  field_e  end_field;

  always_comb begin
    case (field_q)
      F_SCHEMA: value = {32'd0, schema_q};
      F_COUNT:  value = {32'd0, count_q};
      F_SEQ:    value = seq_q;
      F_TS:     value = ts_q;
      F_X:      value = {32'd0, x_q};
      F_Y:      value = {32'd0, y_q};
      F_PRESS:  value = {32'd0, press_q};
      F_PRED:   value = {63'd0, pred_q};
      default:  value = '0;
    endcase
  end

  assign cur_byte  = byte_t'(value >> {byte_q, 3'b000});
  // an empty item that opens a trace stops after the prefix
  assign end_field = carries_q ? F_PRED : F_COUNT;

  fnvsrd_round u_round (
    .digest_i (h_q),
    .byte_i   (cur_byte),
    .digest_o (h_round)
  );

  always_comb begin
    state_d      = state_q;
    field_d      = field_q;
    byte_d       = byte_q;
    h_d          = h_q;
    open_d       = open_q;
    out_valid_d  = out_valid_q;
    out_digest_d = out_digest_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          open_d = 1'b1;
          byte_d = 3'd0;
          if (!open_q) begin
            // new trace: prefix first (digest already at the offset basis)
            field_d = F_SCHEMA;
            state_d = ST_RUN;
          end else if (sample_i.carries_sample) begin
            field_d = F_SEQ;
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        h_d    = h_round;
        byte_d = byte_q + 3'd1;
        if (byte_q == BYTE_LAST) begin
          field_d = field_e'(field_q + 3'd1);
          if (field_q == end_field) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || digest_o.ready) begin
          // output slot free (or emptying now): hand over and close the trace
          out_valid_d  = 1'b1;
          out_digest_d = h_q;
          h_d          = FNV_OFFSET;
          open_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      field_q     <= F_SCHEMA;
      byte_q      <= 3'd0;
      h_q         <= FNV_OFFSET;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      field_q     <= field_d;
      byte_q      <= byte_d;
      h_q         <= h_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_digest_q <= out_digest_d;
  end

  assign digest_o.valid  = out_valid_q;
  assign digest_o.digest = out_digest_q;

`ifndef ASSERT_OFF
  // a closed trace always sits at the offset basis
  a_closed_at_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (h_q == FNV_OFFSET))
    else $error("digest not at offset basis while no trace open");

  // a word that opens a trace starts on the schema version, byte 0
  a_open_starts_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !open_q) |=> (state_q == ST_RUN && field_q == F_SCHEMA && byte_q == 3'd0))
    else $error("trace opened without absorbing the prefix");

  // a word without a sample never runs past the prefix fields
  a_field_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !carries_q) |-> (field_q == F_SCHEMA || field_q == F_COUNT))
    else $error("empty word absorbed sample bytes");

  // closing a trace presents the digest and resets the running digest
  a_emit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && last_q && (!out_valid_q || digest_o.ready))
      |=> (out_valid_q && !open_q && out_digest_q == $past(h_q)))
    else $error("digest emission did not close the trace");
`endif

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FNV-1a 64-bit sample record digest. Traces of
// sample words go in and digest words come out. The digests are checked against a
// bit-exact digest predictor kept inside the bench. Directed cases come
// first, then random traces under several register settings, with random
// gaps and stalls on both sides and one long hold-off on the digest side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fnvsrd_pkg::*;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned MAX_GAP       = 17;
  // The longest busy stretch absorbs 64 bytes; leave some margin.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 195;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_WORDS    = 8;

  // FNV-1a 64-bit prime, 2^40 + 0x1b3
  localparam word64_t  FNV_PRIME64  = 64'h0000_0100_0000_01b3;
  // Index outside the register map; the write must be accepted and ignored.
  localparam cfg_idx_t CFG_UNMAPPED = cfg_idx_t'(15);

  typedef struct {
    word64_t seq;
    word64_t stamp;
    word32_t x;
    word32_t y;
    word32_t pressure;
    logic    predicted;
    logic    carries;
    logic    last;
  } sample_t;

  logic clk;
  logic rst_n;

  fnvsrd_cfg_if    cfg_if ();
  fnvsrd_sample_if sample_if ();
  fnvsrd_digest_if digest_if ();

  fnv1a64_sample_record_digest uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_if),
    .sample_i (sample_if),
    .digest_o (digest_if)
  );

  // Shadow of the block: registers as written, the running digest and
  // whether the prefix of the current trace has been absorbed.
  word32_t     schema_shadow;
  word32_t     count_shadow;
  word64_t     digest_acc;
  bit          trace_open;
  word64_t     pending_digests[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned stall_cycles = 0;  // one-off digest hold-off, taken by the receiver
  bit          idling_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Digest predictor
  // --------------------------------------------------------------------------

  // One value widened to 64 bits, absorbed as eight bytes, low byte first.
  function automatic word64_t fnv_fold64(word64_t h, word64_t v);
    word64_t acc;
    acc = h;
    for (int k = 0; k < 8; k++) begin
      acc = (acc ^ word64_t'(v[8*k +: 8])) * FNV_PRIME64;
    end
    return acc;
  endfunction

  // Called on every accepted sample word; queues the digest when the word
  // closes a trace. Registers are only looked at when a trace opens.
  function automatic void digest_sample(sample_t s);
    word64_t h;
    if (!trace_open) begin
      h          = fnv_fold64(FNV_OFFSET, word64_t'(schema_shadow));
      digest_acc = fnv_fold64(h, word64_t'(count_shadow));
      trace_open = 1'b1;
    end
    h = digest_acc;
    if (s.carries) begin
      h = fnv_fold64(h, s.seq);
      h = fnv_fold64(h, s.stamp);
      h = fnv_fold64(h, word64_t'(s.x));
      h = fnv_fold64(h, word64_t'(s.y));
      h = fnv_fold64(h, word64_t'(s.pressure));
      h = fnv_fold64(h, word64_t'(s.predicted));
    end
    digest_acc = h;
    if (s.last) begin
      pending_digests.push_back(h);
      digest_acc = FNV_OFFSET;
      trace_open = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned draw_gap();
    if (!idling_on) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly random, with the occasional all-zero or all-one value.
  function automatic word64_t rand_wide();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic word32_t rand_narrow();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t make_sample(word64_t seq, word64_t stamp, word32_t x,
                                          word32_t y, word32_t pressure, logic predicted,
                                          logic carries, logic last);
    sample_t s;
    s.seq       = seq;
    s.stamp     = stamp;
    s.x         = x;
    s.y         = y;
    s.pressure  = pressure;
    s.predicted = predicted;
    s.carries   = carries;
    s.last      = last;
    return s;
  endfunction

  function automatic sample_t rand_sample(logic carries, logic last);
    return make_sample(rand_wide(), rand_wide(), rand_narrow(), rand_narrow(),
                       rand_narrow(), logic'($urandom_range(0, 1)), carries, last);
  endfunction

  // Entered and left just after a falling edge. valid is left high so that
  // back-to-back words need no extra edge; settle() drops it.
  task automatic send_word(sample_t s);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.sequence_number <= s.seq;
    sample_if.timestamp_ns    <= s.stamp;
    sample_if.x_bits          <= s.x;
    sample_if.y_bits          <= s.y;
    sample_if.pressure_bits   <= s.pressure;
    sample_if.predicted       <= s.predicted;
    sample_if.carries_sample  <= s.carries;
    sample_if.last_of_trace   <= s.last;
    sample_if.valid           <= 1'b1;
    do @(posedge clk); while (!sample_if.ready);
    digest_sample(s);
    words_sent++;
    @(negedge clk);
  endtask

  // Wait for every digest, then long enough for a word that closes no trace.
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (pending_digests.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_reg(cfg_idx_t idx, word32_t value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_SCHEMA_VERSION) schema_shadow = value;
    else if (idx == CFG_SAMPLE_COUNT) count_shadow = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // n samples; now and then a sample-free word slipped in, and some traces
  // closed by a sample-free word rather than by the last sample.
  task automatic send_trace(int unsigned n);
    bit tail;
    tail = (n == 0) || ($urandom_range(0, 7) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(rand_sample(1'b0, 1'b0));
      send_word(rand_sample(1'b1, (i == n - 1) && !tail));
    end
    if (tail) send_word(rand_sample(1'b0, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: an empty trace gives the digest of the prefix alone, then a one-sample trace.
  task automatic test_reset_defaults();
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1));
  endtask

  // Every field at both extremes and in both alternating patterns; a
  // sample-free word inside a trace must not disturb the digest.
  task automatic test_field_extremes();
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0));
    send_word(make_sample('1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b0));
    send_word(make_sample('1, '1, '1, '1, '1, 1'b1, 1'b0, 1'b0));
    send_word(make_sample(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1, 1'b1));
    send_word(make_sample(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                          32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b1, 1'b0));
    send_word(make_sample('1, '0, '1, '0, '1, 1'b1, 1'b0, 1'b1));
  endtask

  // Registers at their extremes, a count that disagrees with the trace, and
  // a write to an unmapped index that must change nothing.
  task automatic test_register_extremes();
    settle();
    write_reg(CFG_SCHEMA_VERSION, '0);
    write_reg(CFG_SAMPLE_COUNT, '0);
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    settle();
    write_reg(CFG_SCHEMA_VERSION, '1);
    write_reg(CFG_SAMPLE_COUNT, '1);
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    send_word(rand_sample(1'b1, 1'b1));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 32'd3);
    send_word(rand_sample(1'b1, 1'b1));
    settle();
    write_reg(CFG_UNMAPPED, '1);
    send_word(rand_sample(1'b1, 1'b1));
  endtask

  // A write while a trace is open only takes effect on the next trace.
  task automatic test_write_mid_trace();
    settle();
    send_word(rand_sample(1'b1, 1'b0));
    settle();
    write_reg(CFG_SCHEMA_VERSION, 32'd7);
    write_reg(CFG_SAMPLE_COUNT, 32'd2);
    send_word(rand_sample(1'b1, 1'b1));
    send_word(make_sample('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
  endtask

  // Digest side held off for a long stretch while samples keep coming, so
  // the block backs up and stalls its input.
  task automatic test_backpressure();
    settle();
    idling_on    = 1'b0;
    stall_cycles = HOLD_CYCLES;
    repeat (HOLD_WORDS) send_word(rand_sample(1'b1, 1'b1));
    settle();
    idling_on = 1'b1;
  endtask

  // Random traces in phases, each with its own register setting; one phase
  // in three runs without any idling.
  task automatic test_random_traces();
    int unsigned target;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin
          write_reg(CFG_SCHEMA_VERSION, $urandom);
          write_reg(CFG_SAMPLE_COUNT, $urandom);
        end
        1: begin
          write_reg(CFG_SCHEMA_VERSION, '0);
          write_reg(CFG_SAMPLE_COUNT, '0);
        end
        2: begin
          write_reg(CFG_SCHEMA_VERSION, '1);
          write_reg(CFG_SAMPLE_COUNT, '1);
        end
        default: begin
          write_reg(CFG_SCHEMA_VERSION, $urandom_range(1, 4));
          write_reg(CFG_SAMPLE_COUNT, $urandom_range(0, 8));
        end
      endcase
      idling_on = (p % 3 != 2);
      target    = words_sent + PHASE_WORDS;
      while (words_sent < target) send_trace($urandom_range(0, 6));
    end
    settle();
    idling_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Digest receiver: a random stall before each word, or the one-off
  // hold-off when a test asks for it.
  // --------------------------------------------------------------------------
  initial begin : digest_receiver
    int unsigned gap;
    digest_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap          = (stall_cycles != 0) ? stall_cycles : draw_gap();
      stall_cycles = 0;
      if (gap != 0) begin
        digest_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      digest_if.ready <= 1'b1;
      do @(posedge clk); while (!digest_if.valid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Digest checker: each accepted word against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    word64_t want;
    if (rst_n && digest_if.valid && digest_if.ready) begin
      if (pending_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: digest %h arrived with none expected", digest_if.digest);
      end else begin
        want = pending_digests.pop_front();
        if (digest_if.digest !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: digest mismatch, expected %h, got %h", want, digest_if.digest);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    rst_n                     = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = '0;
    cfg_if.data               = '0;
    sample_if.valid           = 1'b0;
    sample_if.sequence_number = '0;
    sample_if.timestamp_ns    = '0;
    sample_if.x_bits          = '0;
    sample_if.y_bits          = '0;
    sample_if.pressure_bits   = '0;
    sample_if.predicted       = 1'b0;
    sample_if.carries_sample  = 1'b0;
    sample_if.last_of_trace   = 1'b0;

    // state after reset
    schema_shadow = 32'd1;
    count_shadow  = 32'd0;
    digest_acc    = FNV_OFFSET;
    trace_open    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_write_mid_trace();
    test_backpressure();
    test_random_traces();
    settle();

    if (pending_digests.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
